// ----- rtl/fhr_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and the state code helper function of the frame header receiver.
package fhr_pkg;

    localparam int BYTE_W = 8;
    localparam int CODE_W = 3;
    localparam int CFG_IDX_W = 3;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_FLAG_BYTE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ADDR_SENDER    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ADDR_RECEIVER  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CTRL_SET       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CTRL_UA        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CTRL_DISC      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_CTRL_INFO_ZERO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_CTRL_INFO_ONE  = 3'd7;

    // Fixed control codes of the supervisory rule set.
    localparam logic [BYTE_W-1:0] CTRL_ACCEPT_HI = 8'h85;
    localparam logic [BYTE_W-1:0] CTRL_ACCEPT_LO = 8'h05;
    localparam logic [BYTE_W-1:0] CTRL_REJECT_LO = 8'h01;
    localparam logic [BYTE_W-1:0] CTRL_REJECT_HI = 8'h81;

    // Reported state codes.
    localparam logic [CODE_W-1:0] CODE_START = 3'd0;
    localparam logic [CODE_W-1:0] CODE_FLAG  = 3'd1;
    localparam logic [CODE_W-1:0] CODE_ADDR  = 3'd2;
    localparam logic [CODE_W-1:0] CODE_CTRL  = 3'd3;
    localparam logic [CODE_W-1:0] CODE_INFO  = 3'd4;
    localparam logic [CODE_W-1:0] CODE_REJ   = 3'd5;
    localparam logic [CODE_W-1:0] CODE_HDR   = 3'd6;
    localparam logic [CODE_W-1:0] CODE_DONE  = 3'd7;

    typedef enum logic [7:0] {
        ST_START = 8'b0000_0001,
        ST_FLAG  = 8'b0000_0010,
        ST_ADDR  = 8'b0000_0100,
        ST_CTRL  = 8'b0000_1000,
        ST_INFO  = 8'b0001_0000,
        ST_REJ   = 8'b0010_0000,
        ST_HDR   = 8'b0100_0000,
        ST_DONE  = 8'b1000_0000
    } fsm_state_t;

    typedef struct packed {
        logic [BYTE_W-1:0] flag_byte;
        logic [BYTE_W-1:0] addr_sender;
        logic [BYTE_W-1:0] addr_receiver;
        logic [BYTE_W-1:0] ctrl_set;
        logic [BYTE_W-1:0] ctrl_ua;
        logic [BYTE_W-1:0] ctrl_disc;
        logic [BYTE_W-1:0] ctrl_info_zero;
        logic [BYTE_W-1:0] ctrl_info_one;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        flag_byte:      8'h7E,
        addr_sender:    8'h03,
        addr_receiver:  8'h01,
        ctrl_set:       8'h03,
        ctrl_ua:        8'h07,
        ctrl_disc:      8'h0B,
        ctrl_info_zero: 8'h00,
        ctrl_info_one:  8'h40
    };

    function automatic logic [CODE_W-1:0] state_code(input fsm_state_t s);
        logic [CODE_W-1:0] code;
        unique case (s)
            ST_START: code = CODE_START;
            ST_FLAG:  code = CODE_FLAG;
            ST_ADDR:  code = CODE_ADDR;
            ST_CTRL:  code = CODE_CTRL;
            ST_INFO:  code = CODE_INFO;
            ST_REJ:   code = CODE_REJ;
            ST_HDR:   code = CODE_HDR;
            ST_DONE:  code = CODE_DONE;
            default:  code = CODE_START;
        endcase
        return code;
    endfunction

endpackage

// ----- rtl/fhr_cfg_regs.sv -----
`timescale 1ns / 1ps
// Configuration register file of the frame header receiver.
module fhr_cfg_regs
    import fhr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [BYTE_W-1:0]    cfg_data,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_FLAG_BYTE:      cfg_reg.flag_byte      <= cfg_data;
                REG_ADDR_SENDER:    cfg_reg.addr_sender    <= cfg_data;
                REG_ADDR_RECEIVER:  cfg_reg.addr_receiver  <= cfg_data;
                REG_CTRL_SET:       cfg_reg.ctrl_set       <= cfg_data;
                REG_CTRL_UA:        cfg_reg.ctrl_ua        <= cfg_data;
                REG_CTRL_DISC:      cfg_reg.ctrl_disc      <= cfg_data;
                REG_CTRL_INFO_ZERO: cfg_reg.ctrl_info_zero <= cfg_data;
                REG_CTRL_INFO_ONE:  cfg_reg.ctrl_info_one  <= cfg_data;
                default:            cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- rtl/fhr_next_state.sv -----
`timescale 1ns / 1ps
// Next-state and capture logic of the frame header state machine.
module fhr_next_state
    import fhr_pkg::*;
(
    input  cfg_t              cfg,
    input  fsm_state_t        state,
    input  logic [BYTE_W-1:0] addr_store,
    input  logic [BYTE_W-1:0] ctrl_store,
    input  logic [BYTE_W-1:0] rx_byte,
    input  logic              frame_kind,
    input  logic              restart,
    output fsm_state_t        state_next,
    output logic [BYTE_W-1:0] addr_next,
    output logic [BYTE_W-1:0] ctrl_next
);

    logic is_flag;
    logic is_addr;
    logic is_info_ctrl;
    logic is_super_ok;
    logic is_super_rej;
    logic is_header;

    always_comb
    begin
        is_flag      = (rx_byte == cfg.flag_byte);
        is_addr      = (rx_byte == cfg.addr_sender) || (rx_byte == cfg.addr_receiver);
        is_info_ctrl = (rx_byte == cfg.ctrl_info_zero) || (rx_byte == cfg.ctrl_info_one);
        is_super_ok  = (rx_byte == cfg.ctrl_ua) || (rx_byte == cfg.ctrl_set)
                    || (rx_byte == cfg.ctrl_disc) || (rx_byte == CTRL_ACCEPT_HI)
                    || (rx_byte == CTRL_ACCEPT_LO);
        is_super_rej = (rx_byte == CTRL_REJECT_LO) || (rx_byte == CTRL_REJECT_HI);
        is_header    = (rx_byte == (addr_store ^ ctrl_store));

        state_next = state;
        addr_next  = addr_store;
        ctrl_next  = ctrl_store;

        if (restart)
        begin
            state_next = ST_START;
        end
        else
        begin
            unique case (state)
                ST_START:
                begin
                    state_next = is_flag ? ST_FLAG : ST_START;
                end
                ST_FLAG:
                begin
                    if (is_addr)
                    begin
                        addr_next  = rx_byte;
                        state_next = ST_ADDR;
                    end
                    else
                    begin
                        state_next = is_flag ? ST_FLAG : ST_START;
                    end
                end
                ST_ADDR:
                begin
                    // The supervisory rule set checks its own codes first; the
                    // flag takes priority over the information codes in both modes.
                    if (!frame_kind && is_super_ok)
                    begin
                        ctrl_next  = rx_byte;
                        state_next = ST_CTRL;
                    end
                    else if (!frame_kind && is_super_rej)
                    begin
                        ctrl_next  = rx_byte;
                        state_next = ST_REJ;
                    end
                    else if (is_flag)
                    begin
                        state_next = ST_FLAG;
                    end
                    else if (is_info_ctrl)
                    begin
                        ctrl_next  = rx_byte;
                        state_next = ST_INFO;
                    end
                    else
                    begin
                        state_next = ST_START;
                    end
                end
                ST_CTRL, ST_INFO:
                begin
                    // A header state of the other rule set holds its place.
                    if ((state == ST_CTRL) == !frame_kind)
                    begin
                        if (is_header)
                        begin
                            state_next = ST_HDR;
                        end
                        else
                        begin
                            state_next = is_flag ? ST_FLAG : ST_START;
                        end
                    end
                end
                ST_HDR:
                begin
                    if (is_flag)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = frame_kind ? ST_HDR : ST_START;
                    end
                end
                ST_REJ, ST_DONE:
                begin
                    state_next = state;
                end
                default:
                begin
                    state_next = ST_START;
                end
            endcase
        end
    end

endmodule

// ----- rtl/frame_header_receiver_fsm.sv -----
`timescale 1ns / 1ps
// Top level of the frame header receiver with input and result registers.
// A request passes the input register and then the result register to the output.
// Throughput is one request per cycle while the output is not stalled.
// Reset clears the valid flags, the state machine and the address and control
// stores, and loads the configuration registers with their default values.
module frame_header_receiver_fsm
    import fhr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [BYTE_W-1:0]    cfg_data,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [7:0]           s_axis_tdata,   // [7:0] rx_byte
    input  logic [1:0]           s_axis_tuser,   // [0] frame_kind, [1] restart
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [23:0]          m_axis_tdata    // [2:0] frame_state, [10:3] seen_address,
                                                 // [18:11] seen_control, [23:19] zero
);

    cfg_t              cfg;
    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              in_kind_reg;
    logic              in_restart_reg;
    logic              out_valid_reg;
    logic [CODE_W-1:0] out_code_reg;
    fsm_state_t        state_reg;
    fsm_state_t        state_next;
    logic [BYTE_W-1:0] addr_reg;
    logic [BYTE_W-1:0] addr_next;
    logic [BYTE_W-1:0] ctrl_reg;
    logic [BYTE_W-1:0] ctrl_next;
    logic              advance;
    logic              step;

    fhr_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    fhr_next_state u_next_state (
        .cfg        (cfg),
        .state      (state_reg),
        .addr_store (addr_reg),
        .ctrl_store (ctrl_reg),
        .rx_byte    (in_byte_reg),
        .frame_kind (in_kind_reg),
        .restart    (in_restart_reg),
        .state_next (state_next),
        .addr_next  (addr_next),
        .ctrl_next  (ctrl_next)
    );

    assign advance       = !out_valid_reg || m_axis_tready;
    assign step          = in_valid_reg && advance;
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_byte_reg    <= s_axis_tdata;
            in_kind_reg    <= s_axis_tuser[0];
            in_restart_reg <= s_axis_tuser[1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_START;
            addr_reg      <= '0;
            ctrl_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (step)
            begin
                state_reg <= state_next;
                addr_reg  <= addr_next;
                ctrl_reg  <= ctrl_next;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_code_reg <= state_code(state_next);
        end
    end

    // The stores themselves are the captured address and control of the result.
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'b0, ctrl_reg, addr_reg, out_code_reg};

endmodule

// ----- rtl/fhr_checker.sv -----
`timescale 1ns / 1ps
// Port-level checker of the frame header receiver and its bind statement.
module fhr_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata
);

    // A stalled result keeps its contents until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

    // The input side only stalls when a result is waiting and the output is blocked.
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled without output back-pressure");

    // The padding bits of a result are always zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[23:19] == 5'b0)
    else $error("result padding is not zero");

endmodule

bind frame_header_receiver_fsm fhr_checker u_fhr_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench of the frame header receiver with directed and random frames.
module tb_top;
    import fhr_pkg::*;

    localparam int PHASES          = 7;
    localparam int ITEMS_PER_PHASE = 170;
    localparam int QUIET_LIMIT     = 1000;
    localparam int DRAIN_CYCLES    = 8;
    localparam int DIRECTED_ROWS   = 25;

    typedef struct packed {
        logic [CODE_W-1:0] state;
        logic [BYTE_W-1:0] address;
        logic [BYTE_W-1:0] control;
    } header_result_t;

    typedef struct packed {
        logic [BYTE_W-1:0] rx;
        logic              kind;
        logic              restart;
        logic              typed;
        header_result_t    want;
    } request_row_t;

    localparam header_result_t UNTYPED = '0;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [BYTE_W-1:0]    cfg_data;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [7:0]           s_axis_tdata;
    logic [1:0]           s_axis_tuser;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [23:0]          m_axis_tdata;

    cfg_t              link_cfg;
    logic [CODE_W-1:0] hdr_state;
    logic [BYTE_W-1:0] addr_seen;
    logic [BYTE_W-1:0] ctrl_seen;
    header_result_t    header_q [$];
    int                sent_count;
    int                error_count;
    int                idle_pct;
    int                stall_pct;

    request_row_t directed_rows [DIRECTED_ROWS] = '{
        '{8'hFF, 1'b1, 1'b1, 1'b1, '{CODE_START, 8'h00, 8'h00}},
        '{8'h00, 1'b0, 1'b0, 1'b1, '{CODE_START, 8'h00, 8'h00}},
        '{8'h7E, 1'b0, 1'b0, 1'b1, '{CODE_FLAG,  8'h00, 8'h00}},
        '{8'h03, 1'b0, 1'b0, 1'b1, '{CODE_ADDR,  8'h03, 8'h00}},
        '{8'h85, 1'b0, 1'b0, 1'b1, '{CODE_CTRL,  8'h03, 8'h85}},
        '{8'h86, 1'b0, 1'b0, 1'b1, '{CODE_HDR,   8'h03, 8'h85}},
        '{8'h12, 1'b0, 1'b0, 1'b1, '{CODE_START, 8'h03, 8'h85}},
        '{8'h7E, 1'b0, 1'b0, 1'b0, UNTYPED},
        '{8'h01, 1'b0, 1'b0, 1'b0, UNTYPED},
        '{8'h01, 1'b0, 1'b0, 1'b1, '{CODE_REJ,   8'h01, 8'h01}},
        '{8'h7E, 1'b1, 1'b0, 1'b1, '{CODE_REJ,   8'h01, 8'h01}},
        '{8'hFF, 1'b0, 1'b1, 1'b1, '{CODE_START, 8'h01, 8'h01}},
        '{8'h7E, 1'b1, 1'b0, 1'b0, UNTYPED},
        '{8'h03, 1'b1, 1'b0, 1'b0, UNTYPED},
        '{8'h40, 1'b1, 1'b0, 1'b0, UNTYPED},
        '{8'h43, 1'b1, 1'b0, 1'b1, '{CODE_HDR,   8'h03, 8'h40}},
        '{8'hFF, 1'b1, 1'b0, 1'b1, '{CODE_HDR,   8'h03, 8'h40}},
        '{8'h7E, 1'b1, 1'b0, 1'b1, '{CODE_DONE,  8'h03, 8'h40}},
        '{8'h00, 1'b0, 1'b0, 1'b1, '{CODE_DONE,  8'h03, 8'h40}},
        '{8'h00, 1'b1, 1'b1, 1'b0, UNTYPED},
        '{8'h7E, 1'b0, 1'b0, 1'b0, UNTYPED},
        '{8'h01, 1'b0, 1'b0, 1'b0, UNTYPED},
        '{8'h00, 1'b0, 1'b0, 1'b0, UNTYPED},
        '{8'h55, 1'b0, 1'b0, 1'b1, '{CODE_INFO,  8'h01, 8'h00}},
        '{8'h07, 1'b1, 1'b1, 1'b1, '{CODE_START, 8'h01, 8'h00}}
    };

    frame_header_receiver_fsm dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic void advance_header_fsm(input logic [BYTE_W-1:0] b, input logic info,
                                               input logic restart);
        logic [CODE_W-1:0] nxt;
        nxt = hdr_state;
        if (restart)
        begin
            nxt = CODE_START;
        end
        else
        begin
            case (hdr_state)
                CODE_START: nxt = (b == link_cfg.flag_byte) ? CODE_FLAG : CODE_START;
                CODE_FLAG:
                begin
                    if (b == link_cfg.addr_sender || b == link_cfg.addr_receiver)
                    begin
                        addr_seen = b;
                        nxt = CODE_ADDR;
                    end
                    else
                    begin
                        nxt = (b == link_cfg.flag_byte) ? CODE_FLAG : CODE_START;
                    end
                end
                CODE_ADDR:
                begin
                    if (!info && (b == link_cfg.ctrl_ua || b == link_cfg.ctrl_set ||
                                  b == link_cfg.ctrl_disc || b == CTRL_ACCEPT_HI ||
                                  b == CTRL_ACCEPT_LO))
                    begin
                        ctrl_seen = b;
                        nxt = CODE_CTRL;
                    end
                    else if (!info && (b == CTRL_REJECT_LO || b == CTRL_REJECT_HI))
                    begin
                        ctrl_seen = b;
                        nxt = CODE_REJ;
                    end
                    else if (b == link_cfg.flag_byte)
                    begin
                        nxt = CODE_FLAG;
                    end
                    else if (b == link_cfg.ctrl_info_zero || b == link_cfg.ctrl_info_one)
                    begin
                        ctrl_seen = b;
                        nxt = CODE_INFO;
                    end
                    else
                    begin
                        nxt = CODE_START;
                    end
                end
                CODE_CTRL, CODE_INFO:
                begin
                    // Each control state only checks the header in its own mode.
                    if (info == (hdr_state == CODE_INFO))
                    begin
                        if (b == (addr_seen ^ ctrl_seen))
                            nxt = CODE_HDR;
                        else
                            nxt = (b == link_cfg.flag_byte) ? CODE_FLAG : CODE_START;
                    end
                end
                CODE_HDR:
                begin
                    if (b == link_cfg.flag_byte)
                        nxt = CODE_DONE;
                    else
                        nxt = info ? CODE_HDR : CODE_START;
                end
                default: nxt = hdr_state;
            endcase
        end
        hdr_state = nxt;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned want,
                                   input int unsigned got);
        $display("MISMATCH %s: expected 0x%0h, got 0x%0h at %0t", what, want, got, $time);
        error_count++;
    endtask

    // Called at a rising edge; returns at the edge where the request is taken.
    task automatic send_request(input logic [BYTE_W-1:0] b, input logic kind,
                                input logic restart);
        while ($urandom_range(99) < idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= {restart, kind};
        do
            @(posedge clk);
        while (!s_axis_tready);
        advance_header_fsm(b, kind, restart);
        header_q.push_back('{hdr_state, addr_seen, ctrl_seen});
        sent_count++;
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [BYTE_W-1:0] v);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge clk);
    endtask

    task automatic load_config(input cfg_t c);
        write_register(REG_FLAG_BYTE, c.flag_byte);
        write_register(REG_ADDR_SENDER, c.addr_sender);
        write_register(REG_ADDR_RECEIVER, c.addr_receiver);
        write_register(REG_CTRL_SET, c.ctrl_set);
        write_register(REG_CTRL_UA, c.ctrl_ua);
        write_register(REG_CTRL_DISC, c.ctrl_disc);
        write_register(REG_CTRL_INFO_ZERO, c.ctrl_info_zero);
        write_register(REG_CTRL_INFO_ONE, c.ctrl_info_one);
        cfg_we <= 1'b0;
        link_cfg = c;
    endtask

    function automatic logic [BYTE_W-1:0] pick_control(input logic info);
        logic [BYTE_W-1:0] b;
        b = BYTE_W'($urandom_range(255));
        if (info)
        begin
            case ($urandom_range(7))
                0, 1, 2: b = link_cfg.ctrl_info_zero;
                3, 4, 5: b = link_cfg.ctrl_info_one;
                6:       b = link_cfg.ctrl_set;
                default: ;
            endcase
        end
        else
        begin
            case ($urandom_range(11))
                0, 9: b = link_cfg.ctrl_set;
                1:    b = link_cfg.ctrl_ua;
                2:    b = link_cfg.ctrl_disc;
                3:    b = CTRL_ACCEPT_HI;
                4:    b = CTRL_ACCEPT_LO;
                5:    b = CTRL_REJECT_LO;
                6:    b = CTRL_REJECT_HI;
                7:    b = link_cfg.ctrl_info_zero;
                8:    b = link_cfg.ctrl_info_one;
                default: ;
            endcase
        end
        return b;
    endfunction

    function automatic logic jitter_kind(input logic kind);
        return ($urandom_range(19) == 0) ? ~kind : kind;
    endfunction

    // Mostly well-formed frames with random content, plus noise and broken frames.
    task automatic send_frame();
        logic              kind;
        logic [BYTE_W-1:0] addr;
        logic [BYTE_W-1:0] ctrl;
        logic [BYTE_W-1:0] check;
        kind = 1'($urandom_range(1));
        if ($urandom_range(9) < 8)
            send_request(BYTE_W'($urandom_range(255)), 1'($urandom_range(1)), 1'b1);
        if ($urandom_range(99) < 15)
        begin
            repeat ($urandom_range(4, 1))
                send_request(BYTE_W'($urandom_range(255)), 1'($urandom_range(1)),
                             $urandom_range(15) == 0);
        end
        else
        begin
            send_request(($urandom_range(19) == 0) ? BYTE_W'($urandom_range(255))
                                                   : link_cfg.flag_byte,
                         jitter_kind(kind), 1'b0);
            case ($urandom_range(9))
                0:       addr = BYTE_W'($urandom_range(255));
                1, 2, 3: addr = link_cfg.addr_receiver;
                default: addr = link_cfg.addr_sender;
            endcase
            send_request(addr, jitter_kind(kind), 1'b0);
            ctrl = pick_control(kind);
            send_request(ctrl, jitter_kind(kind), 1'b0);
            check = ($urandom_range(9) == 0) ? BYTE_W'($urandom_range(255)) : addr ^ ctrl;
            send_request(check, jitter_kind(kind), 1'b0);
            if (kind)
            begin
                repeat ($urandom_range(3))
                    send_request(BYTE_W'($urandom_range(255)), jitter_kind(kind), 1'b0);
            end
            send_request(link_cfg.flag_byte, jitter_kind(kind), 1'b0);
        end
    endtask

    always @(posedge clk)
        m_axis_tready <= ($urandom_range(99) >= stall_pct);

    always @(posedge clk)
    begin : result_check
        header_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (header_q.size() == 0)
            begin
                report_mismatch("unrequested result", 0, 32'(m_axis_tdata));
            end
            else
            begin
                want = header_q.pop_front();
                if (m_axis_tdata[2:0] !== want.state)
                    report_mismatch("frame_state", 32'(want.state), 32'(m_axis_tdata[2:0]));
                if (m_axis_tdata[10:3] !== want.address)
                    report_mismatch("seen_address", 32'(want.address),
                                    32'(m_axis_tdata[10:3]));
                if (m_axis_tdata[18:11] !== want.control)
                    report_mismatch("seen_control", 32'(want.control),
                                    32'(m_axis_tdata[18:11]));
            end
        end
    end

    initial
    begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < QUIET_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("** frame_header_receiver_fsm: FAILED **");
        $finish;
    end

    initial
    begin : stimulus
        bit paused;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        m_axis_tready = 1'b0;
        idle_pct      = 0;
        stall_pct     = 0;
        sent_count    = 0;
        error_count   = 0;
        paused        = 1'b0;
        link_cfg      = CFG_RESET;
        hdr_state     = CODE_START;
        addr_seen     = '0;
        ctrl_seen     = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < DIRECTED_ROWS; i++)
        begin
            send_request(directed_rows[i].rx, directed_rows[i].kind, directed_rows[i].restart);
            if (directed_rows[i].typed)
                header_q[header_q.size() - 1] = directed_rows[i].want;
        end

        for (int phase = 0; phase < PHASES; phase++)
        begin
            if (phase != 0)
            begin
                s_axis_tvalid <= 1'b0;
                do
                    @(posedge clk);
                while (header_q.size() != 0);
                repeat (DRAIN_CYCLES) @(posedge clk);
                case (phase)
                    1:       load_config('0);
                    2:       load_config('1);
                    default: load_config({$urandom, $urandom});
                endcase
            end
            case (phase % 4)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 62; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 62; end
                default: begin idle_pct = 35; stall_pct = 35; end
            endcase
            while (sent_count < DIRECTED_ROWS + (phase + 1) * ITEMS_PER_PHASE)
            begin
                if (phase == 3 && !paused && sent_count > DIRECTED_ROWS + 3 * ITEMS_PER_PHASE + 60)
                begin
                    // Let the pipeline run dry before sending more requests.
                    paused = 1'b1;
                    s_axis_tvalid <= 1'b0;
                    do
                        @(posedge clk);
                    while (header_q.size() != 0);
                end
                send_frame();
            end
        end

        s_axis_tvalid <= 1'b0;
        while (header_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("** frame_header_receiver_fsm: PASSED **");
        else
            $display("** frame_header_receiver_fsm: FAILED **");
        $finish;
    end

endmodule
